@@ src/rrpf_pkg.sv @@
// rrpf_pkg: shared types, register codes and the Q1.14 sine table
// for the rotated rectangle pixel fill block. No dependencies.
package rrpf_pkg;

  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 4'd0,
    REG_CENTER_Y     = 4'd1,
    REG_SIDE_WIDTH   = 4'd2,
    REG_SIDE_HEIGHT  = 4'd3,
    REG_SCALE_FACTOR = 4'd4,
    REG_ANGLE_DEG    = 4'd5,
    REG_BOUND_RADIUS = 4'd6,
    REG_FILL_COLOR   = 4'd7
  } cfg_reg_t;

  localparam logic [8:0] DEG_360 = 9'd360;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_90  = 9'd90;

  // round(16384*sin(k deg)), k = 0..90
  localparam logic [14:0] SIN_Q14 [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
    15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
    15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
    15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
    15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
    15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
    15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
    15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
    15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
    15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
    15'd13421, 15'd13583, 15'd13741, 15'd13895, 15'd14044,
    15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
    15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15492, 15'd15582, 15'd15668, 15'd15750,
    15'd15826, 15'd15898, 15'd15964, 15'd16026, 15'd16083,
    15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
    15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
    15'd16384
  };

  typedef struct packed {
    logic signed [15:0] cs;
    logic signed [15:0] sn;
  } trig_t;

  // geometry derived from the config registers, consumed by the pipeline
  typedef struct packed {
    logic [13:0]        center_x;
    logic [13:0]        center_y;
    logic [9:0]         box_sx;
    logic [10:0]        box_ex;
    logic [9:0]         box_sy;
    logic [10:0]        box_ey;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic [30:0]        lim_u;
    logic [30:0]        lim_v;
    logic [15:0]        color;
  } geom_t;

  // cos and negated sin of a whole-degree angle, wrapped once past 360
  function automatic trig_t trig_of(input logic [8:0] deg);
    logic [8:0]  a;
    logic [8:0]  is;
    logic [8:0]  ic;
    logic [14:0] ts;
    logic [14:0] tc;
    logic        neg_s;
    logic        neg_c;
    trig_t       t;
    a = (deg >= DEG_360) ? deg - DEG_360 : deg;
    if (a <= DEG_90) begin
      is = a;            ic = DEG_90 - a;  neg_s = 1'b0; neg_c = 1'b0;
    end else if (a <= DEG_180) begin
      is = DEG_180 - a;  ic = a - DEG_90;  neg_s = 1'b0; neg_c = 1'b1;
    end else if (a <= DEG_270) begin
      is = a - DEG_180;  ic = DEG_270 - a; neg_s = 1'b1; neg_c = 1'b1;
    end else begin
      is = DEG_360 - a;  ic = a - DEG_270; neg_s = 1'b1; neg_c = 1'b0;
    end
    ts = SIN_Q14[is[6:0]];
    tc = SIN_Q14[ic[6:0]];
    // sn is the negated sine
    t.sn = neg_s ? $signed({1'b0, ts}) : -$signed({1'b0, ts});
    t.cs = neg_c ? -$signed({1'b0, tc}) : $signed({1'b0, tc});
    return t;
  endfunction

endpackage

@@ src/rrpf_cfg.sv @@
// rrpf_cfg: configuration registers and the registered geometry derived
// from them (bounding box, trig, limits). Depends on rrpf_pkg.
module rrpf_cfg import rrpf_pkg::*; #(
  parameter int SCREEN_W = 200,
  parameter int SCREEN_H = 120
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output geom_t                geom
);

  logic [13:0] center_x_r;
  logic [13:0] center_y_r;
  logic [9:0]  side_width_r;
  logic [9:0]  side_height_r;
  logic [11:0] scale_factor_r;
  logic [8:0]  angle_deg_r;
  logic [13:0] bound_radius_r;
  logic [15:0] fill_color_r;
  geom_t       geom_r;
  geom_t       geom_nxt;
  trig_t       trig;
  logic [14:0] end_x;
  logic [14:0] end_y;
  logic [21:0] prod_w;
  logic [21:0] prod_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= 14'd0;
      center_y_r     <= 14'd0;
      side_width_r   <= 10'd16;
      side_height_r  <= 10'd16;
      scale_factor_r <= 12'd256;
      angle_deg_r    <= 9'd0;
      bound_radius_r <= 14'd0;
      fill_color_r   <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:     center_x_r     <= cfg_data[13:0];
        REG_CENTER_Y:     center_y_r     <= cfg_data[13:0];
        REG_SIDE_WIDTH:   side_width_r   <= cfg_data[9:0];
        REG_SIDE_HEIGHT:  side_height_r  <= cfg_data[9:0];
        REG_SCALE_FACTOR: scale_factor_r <= cfg_data[11:0];
        REG_ANGLE_DEG:    angle_deg_r    <= cfg_data[8:0];
        REG_BOUND_RADIUS: bound_radius_r <= cfg_data[13:0];
        REG_FILL_COLOR:   fill_color_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    trig   = trig_of(angle_deg_r);
    end_x  = {1'b0, center_x_r} + {1'b0, bound_radius_r};
    end_y  = {1'b0, center_y_r} + {1'b0, bound_radius_r};
    prod_w = 22'(side_width_r)  * 22'(scale_factor_r);
    prod_h = 22'(side_height_r) * 22'(scale_factor_r);

    geom_nxt.center_x = center_x_r;
    geom_nxt.center_y = center_y_r;
    geom_nxt.box_sx   = (center_x_r >= bound_radius_r) ?
                        10'((center_x_r - bound_radius_r) >> 4) : 10'd0;
    geom_nxt.box_sy   = (center_y_r >= bound_radius_r) ?
                        10'((center_y_r - bound_radius_r) >> 4) : 10'd0;
    // upper box edge clamped to the screen
    geom_nxt.box_ex   = (end_x[14:4] > 11'(SCREEN_W)) ? 11'(SCREEN_W) : end_x[14:4];
    geom_nxt.box_ey   = (end_y[14:4] > 11'(SCREEN_H)) ? 11'(SCREEN_H) : end_y[14:4];
    geom_nxt.cs       = trig.cs;
    geom_nxt.sn       = trig.sn;
    geom_nxt.lim_u    = {prod_w, 9'd0};
    geom_nxt.lim_v    = {prod_h, 9'd0};
    geom_nxt.color    = fill_color_r;
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

@@ src/rrpf_pipe.sv @@
// rrpf_pipe: four-stage pixel pipeline (input register, offsets and box
// test, products, rotated compare into result). Depends on rrpf_pkg.
module rrpf_pipe import rrpf_pkg::*; #(
  parameter int SCREEN_W = 200
) (
  input  logic        clk,
  input  logic        rst_n,
  input  geom_t       geom,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_pixel_col,
  input  logic [9:0]  in_pixel_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_hit,
  output logic [20:0] out_byte_address,
  output logic [15:0] out_pixel_color
);

  // stage 0: input register
  logic               s0_valid_r;
  logic [9:0]         s0_col_r;
  logic [9:0]         s0_row_r;
  // stage 1: offsets and box test
  logic               s1_valid_r;
  logic [9:0]         s1_col_r;
  logic [9:0]         s1_row_r;
  logic signed [14:0] s1_dx_r;
  logic signed [14:0] s1_dy_r;
  logic               s1_inbox_r;
  // stage 2: rotation products and linear pixel index
  logic               s2_valid_r;
  logic signed [30:0] s2_dxc_r;
  logic signed [30:0] s2_dysn_r;
  logic signed [30:0] s2_dxsn_r;
  logic signed [30:0] s2_dyc_r;
  logic [19:0]        s2_lin_r;
  logic               s2_inbox_r;
  // result register
  logic               out_valid_r;
  logic               out_write_hit_r;
  logic [20:0]        out_byte_address_r;
  logic [15:0]        out_pixel_color_r;

  logic               rdy0;
  logic               rdy1;
  logic               rdy2;
  logic               rdy3;
  logic signed [14:0] dx_nxt;
  logic signed [14:0] dy_nxt;
  logic               inbox_nxt;
  logic [20:0]        lin_nxt;
  logic signed [31:0] u;
  logic signed [31:0] v;
  logic [31:0]        abs_u;
  logic [31:0]        abs_v;
  logic               hit_nxt;

  // a stage takes new data when empty or when its contents move on
  assign rdy3     = !out_valid_r || !out_stall;
  assign rdy2     = !s2_valid_r || rdy3;
  assign rdy1     = !s1_valid_r || rdy2;
  assign rdy0     = !s0_valid_r || rdy1;
  assign in_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy0) s0_valid_r  <= in_valid;
      if (rdy1) s1_valid_r  <= s0_valid_r;
      if (rdy2) s2_valid_r  <= s1_valid_r;
      if (rdy3) out_valid_r <= s2_valid_r;
    end
  end

  always_comb begin
    dx_nxt    = $signed({1'b0, s0_col_r, 4'd0}) - $signed({1'b0, geom.center_x});
    dy_nxt    = $signed({1'b0, s0_row_r, 4'd0}) - $signed({1'b0, geom.center_y});
    inbox_nxt = (s0_col_r >= geom.box_sx) && ({1'b0, s0_col_r} < geom.box_ex) &&
                (s0_row_r >= geom.box_sy) && ({1'b0, s0_row_r} < geom.box_ey);
    lin_nxt   = 21'(s1_row_r) * 21'(SCREEN_W) + 21'(s1_col_r);
    u         = {s2_dxc_r[30], s2_dxc_r} - {s2_dysn_r[30], s2_dysn_r};
    v         = {s2_dxsn_r[30], s2_dxsn_r} + {s2_dyc_r[30], s2_dyc_r};
    abs_u     = u[31] ? 32'(-u) : 32'(u);
    abs_v     = v[31] ? 32'(-v) : 32'(v);
    hit_nxt   = s2_inbox_r && (abs_u <= {1'b0, geom.lim_u}) &&
                (abs_v <= {1'b0, geom.lim_v});
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_col_r <= in_pixel_col;
      s0_row_r <= in_pixel_row;
    end
    if (rdy1) begin
      s1_col_r   <= s0_col_r;
      s1_row_r   <= s0_row_r;
      s1_dx_r    <= dx_nxt;
      s1_dy_r    <= dy_nxt;
      s1_inbox_r <= inbox_nxt;
    end
    if (rdy2) begin
      s2_dxc_r   <= 31'(s1_dx_r) * 31'(geom.cs);
      s2_dysn_r  <= 31'(s1_dy_r) * 31'(geom.sn);
      s2_dxsn_r  <= 31'(s1_dx_r) * 31'(geom.sn);
      s2_dyc_r   <= 31'(s1_dy_r) * 31'(geom.cs);
      s2_lin_r   <= lin_nxt[19:0];
      s2_inbox_r <= s1_inbox_r;
    end
    if (rdy3) begin
      out_write_hit_r    <= hit_nxt;
      out_byte_address_r <= hit_nxt ? {s2_lin_r, 1'b0} : 21'd0;
      out_pixel_color_r  <= hit_nxt ? geom.color : 16'd0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_hit    = out_write_hit_r;
  assign out_byte_address = out_byte_address_r;
  assign out_pixel_color  = out_pixel_color_r;

endmodule

@@ src/rotated_rect_pixel_fill.sv @@
// rotated_rect_pixel_fill: one pixel per transfer; one result per cycle
// through the 4-stage pipeline while out_stall is low. Config writes
// pass through the config registers, then the registered geometry.
// Synchronous active-low reset empties the pipeline and restores register
// defaults (side 16, scale 256, all else 0).
// Depends on rrpf_pkg, rrpf_cfg, rrpf_pipe.
module rotated_rect_pixel_fill import rrpf_pkg::*; #(
  parameter int SCREEN_W = 200,
  parameter int SCREEN_H = 120
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [9:0]           in_pixel_col,
  input  logic [9:0]           in_pixel_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_write_hit,
  output logic [20:0]          out_byte_address,
  output logic [15:0]          out_pixel_color
);

  geom_t geom;

  assign cfg_ready = 1'b1;

  rrpf_cfg #(
    .SCREEN_W (SCREEN_W),
    .SCREEN_H (SCREEN_H)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  rrpf_pipe #(
    .SCREEN_W (SCREEN_W)
  ) u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .geom             (geom),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_hit    (out_write_hit),
    .out_byte_address (out_byte_address),
    .out_pixel_color  (out_pixel_color)
  );

endmodule
